/* hdl/dqb_pkg.sv */
// ============================================================================
// dqb_pkg
// shared types and constants of the dns query message encoder
// ============================================================================
`default_nettype none

package dqb_pkg;

  // label store geometry
  localparam int MAX_LABEL   = 63;
  localparam int STORE_DEPTH = 63;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 6;

  // message layout
  localparam int HDR_BYTES  = 12;
  localparam int QUES_BYTES = 5;
  localparam int CNT_W      = 6;

  localparam logic [15:0] RD_BIT   = 16'h0100;
  localparam logic [7:0]  DOT_CHAR = 8'h2E;

  // input operations
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CHAR   = 2'd1,
    OP_END    = 2'd2,
    OP_FINISH = 2'd3
  } dqb_op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_QUERY_TYPE  = 2'd0;
  localparam logic [1:0] CFG_QUERY_CLASS = 2'd1;
  localparam logic [1:0] CFG_RECURSION   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEADER,
    ST_LENGTH,
    ST_LABEL,
    ST_QUESTION
  } dqb_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] name_char;
  } dqb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       label_overflow;
  } dqb_out_t;

  typedef struct packed {
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        recursion_desired;
  } dqb_cfg_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] label_length;
  } dqb_status_t;

endpackage

`default_nettype wire

/* hdl/dqb_label_ram.sv */
// ============================================================================
// dqb_label_ram
// simple dual-port synchronous ram, one write and one registered read port
// ============================================================================
`default_nettype none

module dqb_label_ram #(
  parameter int DEPTH  = 63,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/dqb_engine.sv */
// ============================================================================
// dqb_engine
// item decoder, byte sequencer and output register of the query encoder
// ============================================================================
`default_nettype none

module dqb_engine
  import dqb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dqb_cfg_t          cfg,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire dqb_in_t           item,
  output logic                   msg_valid,
  input  wire logic              msg_stall,
  output dqb_out_t               msg,
  output logic                   ram_wr_en,
  output logic      [ADDR_W-1:0] ram_wr_addr,
  output logic      [7:0]        ram_wr_data,
  output logic                   ram_rd_en,
  output logic      [ADDR_W-1:0] ram_rd_addr,
  input  wire logic [7:0]        ram_rd_data,
  output dqb_status_t            status
);

  dqb_state_t       state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] label_length;
  logic             overflow_seen;
  logic [15:0]      query_id;

  logic             accept;
  logic             load;
  logic             emit;
  logic             last;
  logic             flag;
  logic [7:0]       obyte;
  logic             is_dot;
  logic             store_char;
  logic             drop_char;
  logic             flush_done;
  logic [15:0]      opts;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign load       = !msg_valid || !msg_stall;
  assign is_dot     = (item.name_char == DOT_CHAR);
  assign store_char = accept && (item.operation == OP_CHAR) && !is_dot
                      && (label_length < LEN_W'(MAX_LABEL));
  assign drop_char  = accept && (item.operation == OP_CHAR) && !is_dot
                      && !(label_length < LEN_W'(MAX_LABEL));
  assign opts       = cfg.recursion_desired ? RD_BIT : 16'h0000;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (item.operation)
            OP_START:  state_next = ST_HEADER;
            OP_CHAR:   state_next = is_dot ? ST_LENGTH : ST_IDLE;
            OP_END:    state_next = ST_LENGTH;
            OP_FINISH: state_next = ST_QUESTION;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_HEADER: begin
        if (load && cnt == CNT_W'(HDR_BYTES - 1)) state_next = ST_IDLE;
      end
      ST_LENGTH: begin
        if (load) state_next = (label_length == '0) ? ST_IDLE : ST_LABEL;
      end
      ST_LABEL: begin
        if (load && last) state_next = ST_IDLE;
      end
      ST_QUESTION: begin
        if (load && cnt == CNT_W'(QUES_BYTES - 1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit        = 1'b0;
    last        = 1'b0;
    flag        = 1'b0;
    obyte       = 8'h00;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = store_char;
    ram_wr_addr = label_length[ADDR_W-1:0];
    ram_wr_data = item.name_char;
    flush_done  = 1'b0;
    case (state)
      ST_HEADER: begin
        emit = 1'b1;
        last = (cnt == CNT_W'(HDR_BYTES - 1));
        case (cnt)
          CNT_W'(0): obyte = query_id[15:8];
          CNT_W'(1): obyte = query_id[7:0];
          CNT_W'(2): obyte = opts[15:8];
          CNT_W'(3): obyte = opts[7:0];
          CNT_W'(5): obyte = 8'h01;
          default:   obyte = 8'h00;
        endcase
      end
      ST_LENGTH: begin
        emit        = 1'b1;
        flag        = overflow_seen;
        obyte       = {{(8 - LEN_W){1'b0}}, label_length};
        last        = (label_length == '0);
        ram_rd_en   = load && !last;
        ram_rd_addr = '0;
        flush_done  = load && last;
      end
      ST_LABEL: begin
        emit        = 1'b1;
        flag        = overflow_seen;
        obyte       = ram_rd_data;
        last        = (cnt == label_length - LEN_W'(1));
        ram_rd_en   = load && !last;
        ram_rd_addr = ADDR_W'(cnt + CNT_W'(1));
        flush_done  = load && last;
      end
      ST_QUESTION: begin
        emit = 1'b1;
        last = (cnt == CNT_W'(QUES_BYTES - 1));
        case (cnt)
          CNT_W'(1): obyte = cfg.query_type[15:8];
          CNT_W'(2): obyte = cfg.query_type[7:0];
          CNT_W'(3): obyte = cfg.query_class[15:8];
          CNT_W'(4): obyte = cfg.query_class[7:0];
          default:   obyte = 8'h00;
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      label_length  <= '0;
      overflow_seen <= 1'b0;
      query_id      <= '0;
      msg_valid     <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_IDLE) begin
        cnt <= '0;
      end else if (load && !(state == ST_LENGTH)) begin
        cnt <= cnt + CNT_W'(1);
      end else if (load) begin
        cnt <= '0;
      end

      if (accept && item.operation == OP_START) begin
        label_length  <= '0;
        overflow_seen <= 1'b0;
      end else if (store_char) begin
        label_length <= label_length + LEN_W'(1);
      end else if (drop_char) begin
        overflow_seen <= 1'b1;
      end else if (flush_done) begin
        label_length  <= '0;
        overflow_seen <= 1'b0;
      end

      if (state == ST_HEADER && load && last) begin
        query_id <= query_id + 16'd1;
      end

      if (load) begin
        msg_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg.out_byte       <= obyte;
      msg.last_of_run    <= last;
      msg.label_overflow <= flag;
    end
  end

  assign status.busy         = item_stall;
  assign status.label_length = label_length;

endmodule

`default_nettype wire

/* hdl/dns_query_builder_top.sv */
// ============================================================================
// dns_query_builder_top
// byte-serial dns query message encoder with a label store in ram
// ============================================================================
//
//  channel  handshake               payload              role
//  -------  ----------------------  -------------------  ---------------------
//  item     item_valid/item_stall   item (dqb_in_t)      operation and char in
//  msg      msg_valid/msg_stall     msg (dqb_out_t)      message bytes out
//  cfg      cfg_valid/cfg_ready     cfg_index, cfg_data  register writes
//
//  a name character is written straight into the label ram with no stall
//  after acceptance a start holds item_stall for 12 header bytes, a finish for
//  5 question bytes, a flush for the length and label bytes, one byte a cycle
//  unless msg stalls, via the single output register and one ram read port
//  reset clears control state only; unwritten label entries are never read
//  a stall on msg freezes the sequencer and the ram read data in place
//
`default_nettype none

module dns_query_builder_top
  import dqb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire dqb_in_t     item,
  output logic             msg_valid,
  input  wire logic        msg_stall,
  output dqb_out_t         msg,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dqb_cfg_t          cfg;
  dqb_status_t       status;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  // register writes always complete in one transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.query_type        <= 16'd1;
      cfg.query_class       <= 16'd1;
      cfg.recursion_desired <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUERY_TYPE:  cfg.query_type        <= cfg_data;
        CFG_QUERY_CLASS: cfg.query_class       <= cfg_data;
        CFG_RECURSION:   cfg.recursion_desired <= cfg_data[0];
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

  // label store: writes happen only while idle and reads only while flushing,
  // so the two ports never touch the same entry in one cycle
  dqb_label_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  dqb_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg         (msg),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .status      (status)
  );

  // no message byte is pending straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst && $past(rst) |-> !msg_valid)
    else $error("message byte pending after reset");

  // while more bytes of a run are due, no new item may be taken
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    msg_valid && !msg_stall && !msg.last_of_run |-> item_stall)
    else $error("item taken in the middle of a run");

  // a start drops any pending label
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_START
    |=> status.label_length == '0)
    else $error("label not cleared by start");

  // a stored character grows the label by one
  a_char_grows: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_CHAR
    && item.name_char != DOT_CHAR && status.label_length != LEN_W'(MAX_LABEL)
    |=> status.label_length == $past(status.label_length) + LEN_W'(1))
    else $error("label length not advanced");

endmodule

`default_nettype wire

/* tb/dns_query_builder_top_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// dns_query_builder_top_tb
// self-checking bench for the byte-serial dns query message encoder
// ============================================================================
//
//  A queue of pending items feeds a clocked driver that sends bursts with
//  random gaps between them. The message side stalls in changing modes.
//  A predictor in the bench keeps its own query id, label buffer and
//  register copies, and works out the bytes that each accepted item causes.
//  Every message byte is checked against the oldest expected byte.
//  The run has a short directed part at the reset settings, then random
//  phases. Registers are rewritten only between phases, once the encoder
//  has gone quiet.
//
`default_nettype none

module dns_query_builder_top_tb;
  import dqb_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          SETTLE       = 80;   // longest run is 64 bytes
  localparam int          STALL_LIMIT  = 2000;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 10;
  localparam logic [1:0]  CFG_UNUSED   = 2'd3;

  // ports of the encoder, inputs known from time zero
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  dqb_in_t     item       = '0;
  logic        msg_valid;
  logic        msg_stall  = 1'b0;
  dqb_out_t    msg;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // stimulus and expected bytes
  dqb_in_t     item_pending [$];
  dqb_out_t    msg_expected [$];
  int          items_queued = 0;
  int          errors       = 0;
  int          bytes_seen   = 0;
  int          idle_cycles  = 0;
  logic        item_xfer    = 1'b0;

  // predictor state and register copies
  logic [15:0] next_id;
  logic [7:0]  label_buf [MAX_LABEL];
  int          label_len;
  logic        label_lost;
  logic [15:0] qtype;
  logic [15:0] qclass;
  logic        rd_on;

  // sender and receiver pacing
  int          burst_left = 0;
  int          gap_left   = 0;
  int          stall_mode = 0;
  int          stall_cnt  = 0;
  int          stall_tick = 0;

  dns_query_builder_top uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void emit(input logic [7:0] b, input logic last, input logic ovf);
    dqb_out_t r;
    r.out_byte       = b;
    r.last_of_run    = last;
    r.label_overflow = ovf;
    msg_expected.push_back(r);
  endfunction

  // length byte then the stored bytes, all carrying the overflow flag
  function automatic void flush_label();
    emit(8'(label_len), label_len == 0, label_lost);
    for (int i = 0; i < label_len; i++)
      emit(label_buf[i], i == label_len - 1, label_lost);
    label_len  = 0;
    label_lost = 1'b0;
  endfunction

  function automatic void encode_item(input dqb_in_t it);
    logic [15:0] opts;
    opts = rd_on ? RD_BIT : 16'h0000;
    case (dqb_op_t'(it.operation))
      OP_START: begin
        // a pending label is simply thrown away
        label_len  = 0;
        label_lost = 1'b0;
        emit(next_id[15:8], 1'b0, 1'b0);
        emit(next_id[7:0], 1'b0, 1'b0);
        emit(opts[15:8], 1'b0, 1'b0);
        emit(opts[7:0], 1'b0, 1'b0);
        emit(8'h00, 1'b0, 1'b0);
        emit(8'h01, 1'b0, 1'b0);
        for (int k = 0; k < 6; k++)
          emit(8'h00, k == 5, 1'b0);
        next_id = next_id + 16'd1;
      end
      OP_CHAR: begin
        if (it.name_char == DOT_CHAR) begin
          flush_label();
        end else if (label_len < MAX_LABEL) begin
          label_buf[label_len] = it.name_char;
          label_len++;
        end else begin
          label_lost = 1'b1;
        end
      end
      OP_END: begin
        flush_label();
      end
      default: begin
        emit(8'h00, 1'b0, 1'b0);
        emit(qtype[15:8], 1'b0, 1'b0);
        emit(qtype[7:0], 1'b0, 1'b0);
        emit(qclass[15:8], 1'b0, 1'b0);
        emit(qclass[7:0], 1'b1, 1'b0);
      end
    endcase
  endfunction

  task automatic flag_error(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item per transfer, bursts with random gaps
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : drive
    logic    nv;
    dqb_in_t nd;
    nv = item_valid;
    nd = item;
    if (rst) begin
      nv         = 1'b0;
      gap_left   = 0;
      burst_left = 0;
    end else if (!item_valid || item_xfer) begin
      // last item went across (or nothing was offered), pick the next one
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (item_pending.size() > 0) begin
        nd = item_pending.pop_front();
        nv = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    // a stalled item keeps its payload untouched
    item_valid <= nv;
    item       <= nd;
  end

  // receiver stall: modes of random length, none, light, heavy, periodic
  always @(negedge clk) begin : stall_gen
    logic s;
    s = 1'b0;
    if (!rst) begin
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt  = $urandom_range(20, 150);
      end else begin
        stall_cnt--;
      end
      stall_tick++;
      case (stall_mode)
        0:       s = 1'b0;
        1:       s = ($urandom_range(0, 3) == 0);
        2:       s = ($urandom_range(0, 3) != 0);
        default: s = (stall_tick % 3 == 0);
      endcase
    end
    msg_stall <= s;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks message bytes, feeds the predictor, tracks registers
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    dqb_out_t want;
    if (rst) begin
      item_xfer   <= 1'b0;
      idle_cycles = 0;
      msg_expected.delete();
      next_id    = 16'h0000;
      label_len  = 0;
      label_lost = 1'b0;
      qtype      = 16'h0001;
      qclass     = 16'h0001;
      rd_on      = 1'b1;
    end else begin
      // check first, so a byte never matches an item accepted on this edge
      if (msg_valid && !msg_stall) begin
        if (msg_expected.size() == 0) begin
          flag_error($sformatf("byte %0d (%h) with nothing expected", bytes_seen,
                               msg.out_byte));
        end else begin
          want = msg_expected.pop_front();
          if (msg.out_byte !== want.out_byte)
            flag_error($sformatf("byte %0d out_byte %h, expected %h", bytes_seen,
                                 msg.out_byte, want.out_byte));
          if (msg.last_of_run !== want.last_of_run)
            flag_error($sformatf("byte %0d last_of_run %b, expected %b", bytes_seen,
                                 msg.last_of_run, want.last_of_run));
          if (msg.label_overflow !== want.label_overflow)
            flag_error($sformatf("byte %0d label_overflow %b, expected %b", bytes_seen,
                                 msg.label_overflow, want.label_overflow));
        end
        bytes_seen++;
      end
      if (item_valid && !item_stall)
        encode_item(item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_QUERY_TYPE:  qtype  = cfg_data;
          CFG_QUERY_CLASS: qclass = cfg_data;
          CFG_RECURSION:   rd_on  = cfg_data[0];
          default: ;       // unknown index, write has no effect
        endcase
      end
      item_xfer <= item_valid && !item_stall;
      // only an accepted item counts as progress
      idle_cycles = (item_valid && !item_stall) ? 0 : idle_cycles + 1;
    end
  end

  // watchdog on cycles without an accepted item
  always @(negedge clk) begin
    if (!rst && idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item accepted for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_item(input dqb_op_t op, input logic [7:0] ch);
    dqb_in_t it;
    it.operation = op;
    it.name_char = ch;
    item_pending.push_back(it);
    items_queued++;
  endtask

  // any byte but a dot, so the label stays in one piece
  task automatic push_label(input int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == DOT_CHAR);
      push_item(OP_CHAR, c);
    end
  endtask

  // well-formed query: header, dotted labels, end of name, question
  task automatic push_query(input int nlabels, input int fixed_len);
    int len;
    push_item(OP_START, 8'($urandom_range(0, 255)));
    for (int l = 0; l < nlabels; l++) begin
      if (fixed_len > 0)
        len = fixed_len;
      else if ($urandom_range(0, 15) == 0)
        len = 0;
      else
        len = $urandom_range(1, 8);
      push_label(len);
      if (l < nlabels - 1)
        push_item(OP_CHAR, DOT_CHAR);
    end
    if ($urandom_range(0, 7) == 0)
      push_item(OP_CHAR, DOT_CHAR);  // trailing dot leaves an empty last label
    push_item(OP_END, 8'($urandom_range(0, 255)));
    push_item(OP_FINISH, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_random(input int budget);
    int first;
    int kind;
    first = items_queued;
    while (items_queued - first < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        push_query($urandom_range(1, 4), 0);
      end else if (kind == 7) begin
        // broken query: cut short by a new start, a finish or an end
        push_item(OP_START, 8'h00);
        push_label($urandom_range(1, 6));
        case ($urandom_range(0, 2))
          0:       push_item(OP_START, 8'hFF);
          1:       push_item(OP_FINISH, 8'h00);
          default: push_item(OP_END, 8'h00);
        endcase
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(dqb_op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // sender holds off until every byte is out and the encoder has settled
  task automatic wait_drained();
    do @(negedge clk);
    while (item_pending.size() != 0 || item_valid || msg_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at reset settings
    @(posedge clk);
    push_item(OP_START,  8'h00);
    push_item(OP_CHAR,   8'h00);     // nul is stored like any byte
    push_item(OP_CHAR,   8'hFF);
    push_item(OP_CHAR,   8'h61);
    push_item(OP_CHAR,   DOT_CHAR);
    push_item(OP_CHAR,   DOT_CHAR);  // empty label
    push_item(OP_CHAR,   8'h55);
    push_item(OP_CHAR,   8'hAA);
    push_item(OP_END,    8'hFF);
    push_item(OP_END,    8'h00);     // end with nothing stored
    push_item(OP_FINISH, 8'hFF);
    push_item(OP_CHAR,   8'h78);
    push_item(OP_CHAR,   8'h79);
    push_item(OP_START,  8'h2E);     // start drops the pending label
    push_item(OP_END,    8'h2E);
    push_item(OP_FINISH, 8'h00);
    push_item(OP_FINISH, 8'h2E);     // out of sequence
    push_item(OP_START,  8'h00);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1: begin
          write_reg(CFG_QUERY_TYPE,  16'h0000);
          write_reg(CFG_QUERY_CLASS, 16'h0000);
          write_reg(CFG_RECURSION,   16'h0000);
          write_reg(CFG_UNUSED,      16'hFFFF);
          end_writes();
        end
        2: begin
          write_reg(CFG_QUERY_TYPE,  16'hFFFF);
          write_reg(CFG_QUERY_CLASS, 16'hFFFF);
          write_reg(CFG_RECURSION,   16'hFFFF);
          end_writes();
        end
        3, 4: begin
          write_reg(CFG_QUERY_TYPE,  16'($urandom_range(0, 65535)));
          write_reg(CFG_QUERY_CLASS, 16'($urandom_range(0, 65535)));
          write_reg(CFG_RECURSION,   16'($urandom_range(0, 65535)));
          write_reg(CFG_UNUSED,      16'($urandom_range(0, 65535)));
          end_writes();
        end
        5: begin
          write_reg(CFG_QUERY_TYPE,  16'h0001);
          write_reg(CFG_QUERY_CLASS, 16'h0001);
          write_reg(CFG_RECURSION,   16'h0001);
          end_writes();
        end
        default: ;
      endcase
      @(posedge clk);
      if (p == 0) begin
        // label that fills the store and then loses characters
        push_query(1, MAX_LABEL + 2);
      end
      push_random(PHASE_ITEMS);
      wait_drained();
    end

    if (msg_expected.size() != 0)
      flag_error($sformatf("%0d expected bytes never came", msg_expected.size()));
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* dns_query_builder_top.f */
hdl/dqb_pkg.sv
hdl/dqb_label_ram.sv
hdl/dqb_engine.sv
hdl/dns_query_builder_top.sv
tb/dns_query_builder_top_tb.sv
